/* hw/rtl/gcs_pkg.sv */
// Shared types, codes and helpers for the grid collision separation block.
package gcs_pkg;

	// action codes (input tuser) and reply kinds (output tuser)
	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RESOLVE = 2'd2;
	localparam logic [1:0] ACT_NOP     = 2'd3;

	localparam logic [1:0] RPL_WRITE = 2'd0;
	localparam logic [1:0] RPL_READ  = 2'd1;
	localparam logic [1:0] RPL_PASS  = 2'd2;

	// register indexes
	localparam logic CFG_CELL_SIZE = 1'b0;
	localparam logic CFG_UNIT_SIZE = 1'b1;

	localparam logic [7:0] CELL_SIZE_RST = 8'd32;
	localparam logic [7:0] UNIT_SIZE_RST = 8'd10;

	// 0.1 px in Q8
	localparam logic signed [24:0] NUDGE = 25'sd26;

	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = -24'sh800000;

	typedef struct packed {
		logic              active;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_x;
	} unit_t;

	function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
		logic signed [23:0] r;
		if (v > 33'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < 33'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/gcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/grid_collision_separation_top.sv */
// Top level of the uniform-grid collision separation block.
//
// A table of UNIT_COUNT units (Q15.8 position and active flag) lives in one
// RAM; a resolve item bins the active units into GRID_COLS x GRID_ROWS linked
// cell lists (head RAM and next-link RAM) and then visits the units in index
// order, pushing each away from overlapping neighbors in the 3x3 cells around
// it, with each push written back before the next unit is read. After reset
// the unit RAM is swept to zero, tready low. A write goes straight to its
// reply; a read first waits for the RAM data. A resolve clears the heads,
// then sweeps the units twice, skipping inactive ones: the build divides
// each position by the cell size (two 32-step serial divisions) and links
// the unit into its cell list if inside the grid; the resolve sweep scans
// the 3x3 cells and, per overlapping pair, takes a 16-step square root and
// two 32-step divisions in the shared serial units.
// Only one item is worked on at a time; the reply register lets the next item
// be taken while a reply transfer is still pending.
module grid_collision_separation_top #(
	parameter int UNIT_COUNT = 256,
	parameter int GRID_COLS  = 32,
	parameter int GRID_ROWS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // unit_index[7:0], pos_x[31:8], pos_y[55:32], active[56]
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // reply_index[7:0], reply_x[31:8], reply_y[55:32],
	                              // reply_active[56]
	output logic [1:0]  m_tuser,  // reply_kind
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW         = $clog2(UNIT_COUNT);
	localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
	localparam int CW         = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
	localparam int IW         = AW > 8 ? AW : 8;
	localparam int UW         = $bits(gcs_pkg::unit_t);

	typedef enum logic [4:0] {
		ST_UCLR, ST_IDLE, ST_RDW, ST_REPLY, ST_HCLR, ST_URD, ST_UWAIT, ST_DXS,
		ST_DXW, ST_DYS, ST_DYW, ST_BCELL, ST_BHW, ST_UNEXT, ST_RCELL, ST_RHEAD,
		ST_RJW, ST_RCHK, ST_RMX, ST_RMY, ST_RSQC, ST_RSQ, ST_RMUL, ST_RDS,
		ST_RDV, ST_RLINK, ST_RNB, ST_RWB
	} state_t;

	state_t state_q;

	// config
	logic [7:0] cell_size_q, unit_size_q;

	// item and reply
	logic                rng_q;
	logic [1:0]          rp_kind_q;
	logic [7:0]          rp_idx_q;
	logic signed [23:0]  rp_x_q, rp_y_q;
	logic                rp_act_q;
	logic                out_valid_q;
	logic [63:0]         out_data_q;
	logic [1:0]          out_user_q;

	// pass state
	logic [CW-1:0]       cc_q;
	logic [AW-1:0]       i_q, j_q, clr_q;
	logic                res_q;
	logic signed [23:0]  ux_q, uy_q;
	logic signed [17:0]  gx_q, gy_q;
	logic [1:0]          ox_q, oy_q;
	logic [CW-1:0]       cidx_q;
	logic [AW:0]         nxt_q;
	logic signed [24:0]  dxw_q, dyw_q;
	logic signed [16:0]  dx_q, dy_q;
	logic signed [33:0]  prod_q;
	logic [32:0]         sq_q;
	logic [31:0]         lim2_q;
	logic [15:0]         dist_q, ov_q;
	logic                ax_q;
	logic signed [31:0]  px_q, py_q;

	// serial divider
	logic [31:0] div_quo_q;
	logic [16:0] div_rem_q, div_den_q;
	logic [5:0]  div_cnt_q;

	// serial square root
	logic [31:0] sq_v_q;
	logic [16:0] sq_rem_q;
	logic [15:0] sq_root_q;
	logic [4:0]  sq_cnt_q;

	// memories
	logic          uram_we, nram_we, hram_we;
	logic [AW-1:0] uram_waddr, uram_raddr, nram_waddr;
	logic [UW-1:0] uram_wdata, uram_rdata;
	logic [AW:0]   nram_wdata, nram_rdata, hram_wdata, hram_rdata;
	logic [CW-1:0] hram_waddr, hram_raddr;

	gcs_pkg::unit_t u_rd, u_wr;
	assign u_rd = gcs_pkg::unit_t'(uram_rdata);
	assign uram_wdata = UW'(u_wr);

	gcs_ram #(.WIDTH(UW), .DEPTH(UNIT_COUNT)) u_unit_ram (
		.clk(clk), .we(uram_we), .waddr(uram_waddr), .wdata(uram_wdata),
		.raddr(uram_raddr), .rdata(uram_rdata)
	);

	gcs_ram #(.WIDTH(AW + 1), .DEPTH(UNIT_COUNT)) u_next_ram (
		.clk(clk), .we(nram_we), .waddr(nram_waddr), .wdata(nram_wdata),
		.raddr(uram_raddr), .rdata(nram_rdata)
	);

	gcs_ram #(.WIDTH(AW + 1), .DEPTH(CELL_COUNT)) u_head_ram (
		.clk(clk), .we(hram_we), .waddr(hram_waddr), .wdata(hram_wdata),
		.raddr(hram_raddr), .rdata(hram_rdata)
	);

	// input decode
	logic          in_xfer;
	logic [IW-1:0] idx_w;
	logic          in_rng;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign idx_w    = IW'(s_tdata[7:0]);
	assign in_rng   = ({24'd0, s_tdata[7:0]} < 32'(UNIT_COUNT));

	// datapath helpers
	logic [7:0]         cs_eff;
	logic [15:0]        lim;
	logic signed [24:0] lim_s;
	assign cs_eff = (cell_size_q == 8'd0) ? 8'd1 : cell_size_q;
	assign lim    = {unit_size_q, 8'd0};
	assign lim_s  = $signed({9'd0, lim});

	logic [17:0] dv_sh;
	logic [18:0] dv_df;
	assign dv_sh = {div_rem_q, div_quo_q[31]};
	assign dv_df = {1'b0, dv_sh} - {2'b00, div_den_q};

	logic [19:0] sq_r2, sq_tr, sq_df;
	assign sq_r2 = {1'b0, sq_rem_q, sq_v_q[31:30]};
	assign sq_tr = {2'b00, sq_root_q, 2'b01};
	assign sq_df = sq_r2 - sq_tr;

	logic signed [24:0] pe, pmag;
	assign pe   = (state_q == ST_DYS) ? 25'(uy_q) : 25'(ux_q);
	assign pmag = pe[24] ? -pe : pe;

	logic signed [18:0] cxs, cys;
	logic               c_in;
	logic [CW-1:0]      c_idx;
	assign cxs   = 19'(gx_q) + $signed({17'd0, ox_q}) - 19'sd1;
	assign cys   = 19'(gy_q) + $signed({17'd0, oy_q}) - 19'sd1;
	assign c_in  = (cxs >= 0) && (cxs < GRID_COLS) && (cys >= 0) && (cys < GRID_ROWS);
	assign c_idx = CW'(32'(cxs[17:0]) * GRID_ROWS + 32'(cys[17:0]));

	logic signed [24:0] dxr, dyr, dxn, dyn;
	logic               coinc;
	assign dxr   = 25'(ux_q) - 25'(u_rd.pos_x);
	assign dyr   = 25'(uy_q) - 25'(u_rd.pos_y);
	assign coinc = (dxr == 25'sd0) && (dyr == 25'sd0);
	assign dxn   = coinc ? ((i_q > j_q) ? gcs_pkg::NUDGE : -gcs_pkg::NUDGE) : dxr;
	assign dyn   = coinc ? ((i_q > j_q) ? gcs_pkg::NUDGE : -gcs_pkg::NUDGE) : dyr;

	logic inb;
	assign inb = (dxw_q < lim_s) && (-dxw_q < lim_s) && (dyw_q < lim_s) && (-dyw_q < lim_s);

	logic signed [16:0] mul_a;
	logic [33:0]        pabs;
	logic signed [32:0] q33, push;
	assign mul_a = ax_q ? dy_q : dx_q;
	assign pabs  = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign q33   = $signed({1'b0, div_quo_q});
	assign push  = prod_q[33] ? -q33 : q33;

	logic signed [32:0] sx, sy;
	assign sx = 33'(ux_q) + 33'(px_q);
	assign sy = 33'(uy_q) + 33'(py_q);

	// memory controls
	always_comb begin
		uram_we    = 1'b0;
		uram_waddr = i_q;
		u_wr       = '0;
		uram_raddr = i_q;
		nram_we    = 1'b0;
		nram_waddr = i_q;
		nram_wdata = '0;
		hram_we    = 1'b0;
		hram_waddr = cidx_q;
		hram_wdata = '0;
		hram_raddr = c_idx;
		unique case (state_q)
			ST_UCLR: begin
				uram_we    = 1'b1;
				uram_waddr = clr_q;
			end
			ST_IDLE: begin
				uram_raddr = idx_w[AW-1:0];
				uram_waddr = idx_w[AW-1:0];
				uram_we    = in_xfer && (s_tuser == gcs_pkg::ACT_WRITE) && in_rng;
				u_wr.pos_x  = s_tdata[31:8];
				u_wr.pos_y  = s_tdata[55:32];
				u_wr.active = s_tdata[56];
			end
			ST_HCLR: begin
				hram_we    = 1'b1;
				hram_waddr = cc_q;
			end
			ST_BCELL: begin
				nram_we = !c_in;
			end
			ST_BHW: begin
				nram_we    = 1'b1;
				nram_wdata = hram_rdata;
				hram_we    = 1'b1;
				hram_wdata = {1'b1, i_q};
			end
			ST_RHEAD: begin
				uram_raddr = hram_rdata[AW-1:0];
			end
			ST_RLINK: begin
				uram_raddr = nxt_q[AW-1:0];
			end
			ST_RWB: begin
				uram_we     = 1'b1;
				u_wr.pos_x  = gcs_pkg::sat24(sx);
				u_wr.pos_y  = gcs_pkg::sat24(sy);
				u_wr.active = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_UCLR;
			cell_size_q <= gcs_pkg::CELL_SIZE_RST;
			unit_size_q <= gcs_pkg::UNIT_SIZE_RST;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
			div_cnt_q   <= '0;
			sq_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gcs_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_wdata;
					gcs_pkg::CFG_UNIT_SIZE: unit_size_q <= cfg_wdata;
				endcase
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			// divider step
			if (div_cnt_q != 6'd0) begin
				div_cnt_q <= div_cnt_q - 6'd1;
				if (!dv_df[18]) begin
					div_rem_q <= dv_df[16:0];
					div_quo_q <= {div_quo_q[30:0], 1'b1};
				end else begin
					div_rem_q <= dv_sh[16:0];
					div_quo_q <= {div_quo_q[30:0], 1'b0};
				end
			end
			// square root step
			if (sq_cnt_q != 5'd0) begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
				sq_v_q   <= {sq_v_q[29:0], 2'b00};
				if (!sq_df[19]) begin
					sq_rem_q  <= sq_df[16:0];
					sq_root_q <= {sq_root_q[14:0], 1'b1};
				end else begin
					sq_rem_q  <= sq_r2[16:0];
					sq_root_q <= {sq_root_q[14:0], 1'b0};
				end
			end

			unique case (state_q)
				ST_UCLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(UNIT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						rp_kind_q <= s_tuser;
						rp_idx_q  <= s_tdata[7:0];
						rp_x_q    <= '0;
						rp_y_q    <= '0;
						rp_act_q  <= 1'b0;
						rng_q     <= in_rng;
						priority case (s_tuser)
							gcs_pkg::ACT_WRITE: state_q <= ST_REPLY;
							gcs_pkg::ACT_READ:  state_q <= ST_RDW;
							gcs_pkg::ACT_RESOLVE: begin
								rp_idx_q <= 8'd0;
								cc_q     <= '0;
								lim2_q   <= 32'(lim) * 32'(lim);
								state_q  <= ST_HCLR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RDW: begin
					if (rng_q) begin
						rp_x_q   <= u_rd.pos_x;
						rp_y_q   <= u_rd.pos_y;
						rp_act_q <= u_rd.active;
					end
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_user_q  <= rp_kind_q;
						out_data_q  <= {7'd0, rp_act_q, rp_y_q, rp_x_q, rp_idx_q};
						state_q     <= ST_IDLE;
					end
				end
				ST_HCLR: begin
					cc_q <= cc_q + CW'(1);
					if (cc_q == CW'(CELL_COUNT - 1)) begin
						i_q     <= '0;
						res_q   <= 1'b0;
						state_q <= ST_URD;
					end
				end
				ST_URD: state_q <= ST_UWAIT;
				ST_UWAIT: begin
					ux_q    <= u_rd.pos_x;
					uy_q    <= u_rd.pos_y;
					state_q <= u_rd.active ? ST_DXS : ST_UNEXT;
				end
				ST_DXS, ST_DYS: begin
					div_quo_q <= 32'(pmag[24:8]);
					div_rem_q <= '0;
					div_den_q <= 17'(cs_eff);
					div_cnt_q <= 6'd32;
					state_q   <= (state_q == ST_DXS) ? ST_DXW : ST_DYW;
				end
				ST_DXW: begin
					if (div_cnt_q == 6'd0) begin
						gx_q <= ux_q[23] ? -$signed({1'b0, div_quo_q[16:0]})
						                 : $signed({1'b0, div_quo_q[16:0]});
						state_q <= ST_DYS;
					end
				end
				ST_DYW: begin
					if (div_cnt_q == 6'd0) begin
						gy_q <= uy_q[23] ? -$signed({1'b0, div_quo_q[16:0]})
						                 : $signed({1'b0, div_quo_q[16:0]});
						// build looks at the unit's own cell, resolve sweeps 3x3
						ox_q    <= res_q ? 2'd0 : 2'd1;
						oy_q    <= res_q ? 2'd0 : 2'd1;
						px_q    <= '0;
						py_q    <= '0;
						state_q <= res_q ? ST_RCELL : ST_BCELL;
					end
				end
				ST_BCELL: begin
					cidx_q  <= c_idx;
					state_q <= c_in ? ST_BHW : ST_UNEXT;
				end
				ST_BHW: state_q <= ST_UNEXT;
				ST_UNEXT: begin
					i_q <= i_q + AW'(1);
					if (i_q == AW'(UNIT_COUNT - 1)) begin
						i_q <= '0;
						if (!res_q) begin
							res_q   <= 1'b1;
							state_q <= ST_URD;
						end else begin
							state_q <= ST_REPLY;
						end
					end else begin
						state_q <= ST_URD;
					end
				end
				ST_RCELL: state_q <= c_in ? ST_RHEAD : ST_RNB;
				ST_RHEAD: begin
					j_q     <= hram_rdata[AW-1:0];
					state_q <= hram_rdata[AW] ? ST_RJW : ST_RNB;
				end
				ST_RJW: begin
					nxt_q <= nram_rdata;
					dxw_q <= dxn;
					dyw_q <= dyn;
					state_q <= ((j_q != i_q) && u_rd.active) ? ST_RCHK : ST_RLINK;
				end
				ST_RCHK: begin
					dx_q    <= dxw_q[16:0];
					dy_q    <= dyw_q[16:0];
					state_q <= inb ? ST_RMX : ST_RLINK;
				end
				ST_RMX: begin
					prod_q  <= 34'(dx_q) * 34'(dx_q);
					state_q <= ST_RMY;
				end
				ST_RMY: begin
					// sum of squares can reach 33 bits
					sq_q    <= 33'(prod_q + 34'(dy_q) * 34'(dy_q));
					state_q <= ST_RSQC;
				end
				ST_RSQC: begin
					if (sq_q < 33'(lim2_q)) begin
						sq_v_q    <= sq_q[31:0];
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						sq_cnt_q  <= 5'd16;
						state_q   <= ST_RSQ;
					end else begin
						state_q <= ST_RLINK;
					end
				end
				ST_RSQ: begin
					if (sq_cnt_q == 5'd0) begin
						dist_q  <= sq_root_q;
						ov_q    <= lim - sq_root_q;
						ax_q    <= 1'b0;
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					prod_q  <= 34'(mul_a) * 34'($signed({1'b0, ov_q}));
					state_q <= ST_RDS;
				end
				ST_RDS: begin
					div_quo_q <= pabs[31:0];
					div_rem_q <= '0;
					div_den_q <= {dist_q, 1'b0};
					div_cnt_q <= 6'd32;
					state_q   <= ST_RDV;
				end
				ST_RDV: begin
					if (div_cnt_q == 6'd0) begin
						if (!ax_q) begin
							px_q    <= px_q + 32'(push);
							ax_q    <= 1'b1;
							state_q <= ST_RMUL;
						end else begin
							py_q    <= py_q + 32'(push);
							state_q <= ST_RLINK;
						end
					end
				end
				ST_RLINK: begin
					j_q     <= nxt_q[AW-1:0];
					state_q <= nxt_q[AW] ? ST_RJW : ST_RNB;
				end
				ST_RNB: begin
					if (oy_q == 2'd2) begin
						oy_q <= 2'd0;
						ox_q <= ox_q + 2'd1;
						state_q <= (ox_q == 2'd2) ? ST_RWB : ST_RCELL;
					end else begin
						oy_q    <= oy_q + 2'd1;
						state_q <= ST_RCELL;
					end
				end
				ST_RWB: state_q <= ST_UNEXT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// no item taken while the unit table is still being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UCLR) |-> !s_tready)
		else $error("input accepted during unit clear");

	// an accepted read enters the RAM data wait state in the following cycle
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tuser == gcs_pkg::ACT_READ) |=> (state_q == ST_RDW))
		else $error("read did not enter data wait");

	// build links only ever insert valid heads
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(hram_we && state_q != ST_HCLR) |-> hram_wdata[AW])
		else $error("head written without valid mark");

	// the serial divider is idle when a new division starts
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDS || state_q == ST_DXS || state_q == ST_DYS) |-> (div_cnt_q == 6'd0))
		else $error("divider restarted while busy");

endmodule

/* dv/gcs_checker.sv */
// Watches the stream and config ports of the collision block, predicts replies and compares them.
`timescale 1ns / 100ps

module gcs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          outstanding,
	output int          fails,
	output int          checked
);

	localparam int UNITS = 256;
	localparam int COLS  = 32;
	localparam int ROWS  = 32;

	typedef struct {
		logic [1:0]         kind;
		logic [7:0]         idx;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               act;
	} reply_t;

	reply_t             reply_q[$];
	logic signed [23:0] tbl_x[UNITS];
	logic signed [23:0] tbl_y[UNITS];
	bit                 tbl_act[UNITS];
	int                 head[COLS*ROWS];
	int                 link[UNITS];
	logic [7:0]         cell_sz;
	logic [7:0]         unit_sz;

	function automatic longint cell_of(longint p);
		longint span;
		span = longint'(cell_sz == 0 ? 1 : cell_sz) * 256;
		return p / span;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > 8388607) return 24'sh7FFFFF;
		if (v < -8388608) return -24'sh800000;
		return v[23:0];
	endfunction

	// bin active units into the cell lists, then push each unit in index order
	task automatic separate_units();
		longint lim, ux, uy, gx, gy, cx, cy, push_x, push_y, dx, dy, root_d, ov;
		longint unsigned sq;
		int c, j;
		lim = longint'(unit_sz) * 256;
		foreach (head[k]) head[k] = -1;
		for (int i = 0; i < UNITS; i++) begin
			if (!tbl_act[i]) continue;
			gx = cell_of(tbl_x[i]);
			gy = cell_of(tbl_y[i]);
			if (gx >= 0 && gx < COLS && gy >= 0 && gy < ROWS) begin
				c = int'(gx) * ROWS + int'(gy);
				link[i] = head[c];
				head[c] = i;
			end else begin
				link[i] = -1;
			end
		end
		for (int i = 0; i < UNITS; i++) begin
			if (!tbl_act[i]) continue;
			ux = tbl_x[i];
			uy = tbl_y[i];
			gx = cell_of(ux);
			gy = cell_of(uy);
			push_x = 0;
			push_y = 0;
			for (cx = gx - 1; cx <= gx + 1; cx++) begin
				if (cx < 0 || cx >= COLS) continue;
				for (cy = gy - 1; cy <= gy + 1; cy++) begin
					if (cy < 0 || cy >= ROWS) continue;
					j = head[int'(cx) * ROWS + int'(cy)];
					while (j >= 0) begin
						if (j != i && tbl_act[j]) begin
							dx = ux - tbl_x[j];
							dy = uy - tbl_y[j];
							// stacked units get a fixed nudge, sign by index order
							if (dx == 0 && dy == 0) begin
								dx = (i > j) ? 26 : -26;
								dy = dx;
							end
							if (dx < lim && -dx < lim && dy < lim && -dy < lim) begin
								sq = longint'(dx * dx + dy * dy);
								if (sq < longint'(lim * lim)) begin
									root_d = longint'(root_floor(sq));
									ov = lim - root_d;
									if (root_d > 0) begin
										push_x += (dx * ov) / (2 * root_d);
										push_y += (dy * ov) / (2 * root_d);
									end
								end
							end
						end
						j = link[j];
					end
				end
			end
			tbl_x[i] = clamp24(ux + push_x);
			tbl_y[i] = clamp24(uy + push_y);
		end
	endtask

	task automatic compare(string what, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t r, e;
		if (!arst_n) begin
			foreach (tbl_x[k]) begin
				tbl_x[k] = '0;
				tbl_y[k] = '0;
				tbl_act[k] = 0;
				link[k] = -1;
			end
			cell_sz = gcs_pkg::CELL_SIZE_RST;
			unit_sz = gcs_pkg::UNIT_SIZE_RST;
			reply_q.delete();
			outstanding = 0;
		end else begin
			// reply side first: a transfer out belongs to an earlier input
			if (m_tvalid && m_tready) begin
				r.kind = m_tuser;
				r.idx  = m_tdata[7:0];
				r.x    = m_tdata[31:8];
				r.y    = m_tdata[55:32];
				r.act  = m_tdata[56];
				if (reply_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected reply kind %0d index %0d", $time, r.kind, r.idx);
				end else begin
					e = reply_q.pop_front();
					compare("reply_kind", e.kind, r.kind);
					compare("reply_index", e.idx, r.idx);
					compare("reply_x", e.x, r.x);
					compare("reply_y", e.y, r.y);
					compare("reply_active", e.act, r.act);
					checked++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == gcs_pkg::CFG_CELL_SIZE) cell_sz = cfg_wdata;
				else unit_sz = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				e.kind = s_tuser;
				e.idx  = s_tdata[7:0];
				e.x    = '0;
				e.y    = '0;
				e.act  = 0;
				case (s_tuser)
					gcs_pkg::ACT_WRITE: begin
						tbl_x[s_tdata[7:0]] = s_tdata[31:8];
						tbl_y[s_tdata[7:0]] = s_tdata[55:32];
						tbl_act[s_tdata[7:0]] = s_tdata[56];
						reply_q.push_back(e);
					end
					gcs_pkg::ACT_READ: begin
						e.x   = tbl_x[s_tdata[7:0]];
						e.y   = tbl_y[s_tdata[7:0]];
						e.act = tbl_act[s_tdata[7:0]];
						reply_q.push_back(e);
					end
					gcs_pkg::ACT_RESOLVE: begin
						separate_units();
						e.idx = '0;
						reply_q.push_back(e);
					end
					default: ; // unused action, no reply
				endcase
			end
			outstanding = reply_q.size();
		end
	end

	initial begin
		fails = 0;
		checked = 0;
		outstanding = 0;
	end

endmodule

/* dv/tb.sv */
// Stimulus and verdict for the grid collision separation block.
`timescale 1ns / 100ps

module tb;

	localparam int WATCHDOG = 1_500_000;  // idle cycles; one dense resolve is far below this
	localparam int DRAIN    = 64;         // settle time after the last reply
	localparam int PHASES   = 5;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = gcs_pkg::ACT_WRITE;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 0;
	logic        cfg_index = gcs_pkg::CFG_CELL_SIZE;
	logic [7:0]  cfg_wdata = '0;

	int outstanding, fails, checked;
	int sent, resolves, stall_cnt;
	int tx_idle, rx_idle;       // idle chance in percent
	logic [7:0] cur_cell, cur_unit;

	// settings walked through, one per phase: reset values, minimum, maximum,
	// zero (cell acts as one pixel, nothing collides), then an odd middle one
	logic [7:0] cell_plan[PHASES] = '{8'd32, 8'd1, 8'd255, 8'd0, 8'd7};
	logic [7:0] unit_plan[PHASES] = '{8'd10, 8'd1, 8'd255, 8'd0, 8'd16};

	grid_collision_separation_top dut (.*);

	gcs_checker chk (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver side: random back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// watchdog: cycles without any transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG) begin
			$display("watchdog expired at %0t", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	// idle mix follows progress through the item stream
	function automatic void pick_idling();
		if (sent < 36) begin
			tx_idle = 21;
			rx_idle = 61;
		end else if (sent < 80) begin
			tx_idle = 61;
			rx_idle = 21;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endfunction

	// one input transfer; returns at the edge where it is taken
	task automatic send(logic [1:0] act, logic [7:0] idx, logic signed [23:0] x,
	                    logic signed [23:0] y, logic a);
		pick_idling();
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, a, y, x, idx};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (act == gcs_pkg::ACT_RESOLVE) resolves++;
	endtask

	// quiet the block before touching a register
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] cs, logic [7:0] us);
		cfg_we    <= 1;
		cfg_index <= gcs_pkg::CFG_CELL_SIZE;
		cfg_wdata <= cs;
		@(posedge clk);
		cfg_index <= gcs_pkg::CFG_UNIT_SIZE;
		cfg_wdata <= us;
		@(posedge clk);
		cfg_we <= 0;
		cur_cell = cs;
		cur_unit = us;
	endtask

	// a cluster of units around one grid point, a pass, then read-back
	task automatic scene();
		int k, span_px, spread, cx, cy;
		logic [7:0] ids[8];
		logic signed [23:0] x, y;
		k = $urandom_range(2, 6);
		span_px = 32 * (cur_cell == 0 ? 1 : cur_cell);
		spread = (cur_unit == 0 ? 1 : cur_unit) * 256;
		cx = $urandom_range(0, span_px - 1) * 256 + $urandom_range(0, 255);
		cy = $urandom_range(0, span_px - 1) * 256 + $urandom_range(0, 255);
		for (int n = 0; n < k; n++) begin
			ids[n] = 8'($urandom_range(0, 15));
			// now and then stack a unit exactly on the previous one
			if (n == 0 || $urandom_range(0, 3) != 0) begin
				x = 24'(cx + $urandom_range(0, 2 * spread) - spread);
				y = 24'(cy + $urandom_range(0, 2 * spread) - spread);
			end
			send(gcs_pkg::ACT_WRITE, ids[n], x, y, $urandom_range(0, 7) != 0);
		end
		// noise: full-range write, a read anywhere, the unused code, or none
		case ($urandom_range(0, 3))
			0: send(gcs_pkg::ACT_WRITE, 8'($urandom), 24'($urandom), 24'($urandom),
			        $urandom_range(0, 3) == 0);
			1: send(gcs_pkg::ACT_READ, 8'($urandom), 24'($urandom), 24'($urandom),
			        1'($urandom));
			2: send(gcs_pkg::ACT_NOP, 8'($urandom), 24'($urandom), 24'($urandom),
			        1'($urandom));
			default: ;
		endcase
		send(gcs_pkg::ACT_RESOLVE, 8'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
		for (int n = 0; n < k; n++) send(gcs_pkg::ACT_READ, ids[n], '0, '0, 0);
	endtask

	initial begin
		sent = 0;
		resolves = 0;
		stall_cnt = 0;
		cur_cell = gcs_pkg::CELL_SIZE_RST;
		cur_unit = gcs_pkg::UNIT_SIZE_RST;
		pick_idling();
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes, stacked units, a neighbor, unused code
		send(gcs_pkg::ACT_WRITE, 8'd0, 24'sh7FFFFF, -24'sh800000, 1);
		send(gcs_pkg::ACT_WRITE, 8'd255, -24'sh800000, 24'sh7FFFFF, 1);
		send(gcs_pkg::ACT_READ, 8'd0, '0, '0, 0);
		send(gcs_pkg::ACT_READ, 8'd255, '0, '0, 0);
		send(gcs_pkg::ACT_WRITE, 8'd1, 24'sd25600, 24'sd25600, 1);
		send(gcs_pkg::ACT_WRITE, 8'd2, 24'sd25600, 24'sd25600, 1);
		send(gcs_pkg::ACT_WRITE, 8'd3, 24'sd26368, 24'sd25000, 1);
		send(gcs_pkg::ACT_WRITE, 8'd4, 24'sd26000, 24'sd25800, 0);
		// slightly negative pixel still lands in cell zero
		send(gcs_pkg::ACT_WRITE, 8'd5, -24'sd100, 24'sd200, 1);
		send(gcs_pkg::ACT_WRITE, 8'd6, 24'sd300, -24'sd50, 1);
		send(gcs_pkg::ACT_NOP, 8'hAA, 24'sh555555, -24'sh2AAAAA, 1);
		send(gcs_pkg::ACT_READ, 8'd200, '0, '0, 0);
		send(gcs_pkg::ACT_RESOLVE, 8'd0, '0, '0, 0);
		for (int n = 0; n <= 6; n++) send(gcs_pkg::ACT_READ, 8'(n), '0, '0, 0);
		send(gcs_pkg::ACT_READ, 8'd255, '0, '0, 0);

		// random: one phase per register setting
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_regs(cell_plan[p], unit_plan[p]);
			repeat (2) scene();
		end

		drain();
		$display("%0d input items, %0d collision passes, %0d replies checked over %0d settings",
		         sent, resolves, checked, PHASES);
		$display("cell and unit sizes covered zero, one, reset, mid and 255");
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_ram.sv
hw/rtl/grid_collision_separation_top.sv
dv/gcs_checker.sv
dv/tb.sv
